// ===== src/des_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package des_pkg;

   // Field widths
   localparam int CODE_W = 6;
   localparam int TIME_W = 32;
   localparam int MASK_W = 64;
   localparam int OCC_W  = 5;

   // Most due events popped by one poll command
   localparam int RESULT_LIMIT = 16;
   localparam int POP_W        = $clog2(RESULT_LIMIT);

   // Command codes (carried on req_tuser)
   localparam logic [2:0] CMD_PUT     = 3'd0;
   localparam logic [2:0] CMD_DELETE  = 3'd1;
   localparam logic [2:0] CMD_POLL    = 3'd2;
   localparam logic [2:0] CMD_CLEAR   = 3'd3;
   localparam logic [2:0] CMD_CORRECT = 3'd4;

   // Result status codes
   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_FULL    = 2'd1;
   localparam logic [1:0] STATUS_INVALID = 2'd2;

   // One table slot
   typedef struct packed {
      logic              occ;
      logic [CODE_W-1:0] code;
      logic [TIME_W-1:0] due;
   } entry_type;

   // Operation applied to every cell in a cycle
   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_APPEND,
      CELL_RETIME,
      CELL_SHIFT,
      CELL_DROP,
      CELL_CLEAR,
      CELL_POP,
      CELL_SORT
   } cell_op_type;

   typedef struct packed {
      cell_op_type       op;
      logic              odd_phase;
      logic [CODE_W-1:0] code;
      logic [TIME_W-1:0] due;
      logic [TIME_W-1:0] delta;
   } cell_ctrl_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SORT,
      ST_DONE,
      ST_POLL
   } state_type;

   // Left neighbour of the head cell: never swaps
   localparam entry_type GUARD_ENTRY = '{occ: 1'b1, code: '0, due: '0};
   // Right neighbour of the tail cell: an empty slot
   localparam entry_type HOLE_ENTRY  = '{occ: 1'b0, code: '0, due: '0};

   // Adjacent pair out of order: empty slots sink to the tail, equal due
   // times never swap so the older entry stays first.
   function automatic logic entry_swap(entry_type l, entry_type r);
      return (!l.occ && r.occ) || (l.occ && r.occ && (l.due > r.due));
   endfunction

endpackage

`default_nettype wire

// ===== src/deadline_event_scheduler_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Steps: put, delete and clock correction pass through an update step, then TABLE_DEPTH sort
//   phases across the cell row, then a done step that registers the result.
//   Clear, rejected puts and deletes and unknown commands skip the sort phases; a poll gives
//   its first result from the poll state and one popped event per cycle after that while rsp_tready allows.
// Commands are taken one at a time: req_tready is high only while idle, after the last result is issued.
// Reset (synchronous): table emptied, clock-correction mask cleared, no result pending.

module deadline_event_scheduler_top #(
   parameter int TABLE_DEPTH = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // configuration
   input  wire logic        csr_wr_en,
   input  wire logic [63:0] csr_wr_data,      // shift_class_mask
   // command stream
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [71:0] req_tdata,        // event_code[5:0], time_value[37:6], now_time[69:38]
   input  wire logic [2:0]  req_tuser,        // command
   // result stream
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,        // status[1:0], fired_event[7:2], occupancy[12:8]
   output logic             rsp_tuser,        // fired_valid
   output logic             rsp_tlast         // last
);

   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int PH_W  = $clog2(TABLE_DEPTH);

   // Configuration register
   logic [des_pkg::MASK_W-1:0] mask_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= '0;
      end else if (csr_wr_en) begin
         mask_ff <= csr_wr_data;
      end
   end

   // Captured command
   logic [2:0]                 cmd_ff;
   logic [des_pkg::CODE_W-1:0] code_ff;
   logic [des_pkg::TIME_W-1:0] tval_ff;
   logic [des_pkg::TIME_W-1:0] now_ff;
   logic [des_pkg::TIME_W-1:0] delta_ff;

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         cmd_ff   <= req_tuser;
         code_ff  <= req_tdata[5:0];
         tval_ff  <= req_tdata[37:6];
         now_ff   <= req_tdata[69:38];
         delta_ff <= req_tdata[37:6] - req_tdata[69:38];
      end
   end

   // Control state
   des_pkg::state_type     state_ff, state_in;
   logic [PH_W-1:0]        phase_ff, phase_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [des_pkg::POP_W-1:0] pop_ff, pop_in;
   logic [1:0]             status_ff, status_in;

   assign req_tready = (state_ff == des_pkg::ST_IDLE);

   // Output register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [15:0]            rsp_data_ff, rsp_data_in;
   logic                   rsp_user_ff, rsp_user_in;
   logic                   rsp_last_ff, rsp_last_in;

   // Cell row
   des_pkg::cell_ctrl_type ctrl;
   des_pkg::entry_type     cell_q [TABLE_DEPTH];

   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      des_pkg::entry_type left_n;
      des_pkg::entry_type right_n;
      if (i == 0) begin : g_head
         assign left_n = des_pkg::GUARD_ENTRY;
      end else begin : g_mid_l
         assign left_n = cell_q[i-1];
      end
      if (i == TABLE_DEPTH - 1) begin : g_tail
         assign right_n = des_pkg::HOLE_ENTRY;
      end else begin : g_mid_r
         assign right_n = cell_q[i+1];
      end
      des_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .shift_mask  (mask_ff),
         .cell_odd    (1'(i % 2)),
         .cell_tail   (1'(i == TABLE_DEPTH - 1)),
         .left_entry  (left_n),
         .right_entry (right_n),
         .entry       (cell_q[i])
      );
   end

   // Held code lookup for put and delete
   logic code_held;

   always_comb begin
      code_held = 1'b0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         if (cell_q[i].occ && (cell_q[i].code == code_ff)) code_held = 1'b1;
      end
   end

   // Poll checks on the head of the row
   logic front_due;
   logic next_due;
   logic out_free;

   assign front_due = cell_q[0].occ && (cell_q[0].due <= now_ff);
   assign next_due  = cell_q[1].occ && (cell_q[1].due <= now_ff);
   assign out_free  = !rsp_valid_ff || rsp_tready;

   // Sequencer
   always_comb begin
      state_in       = state_ff;
      phase_in       = phase_ff;
      count_in       = count_ff;
      pop_in         = pop_ff;
      status_in      = status_ff;
      ctrl.op        = des_pkg::CELL_HOLD;
      ctrl.odd_phase = phase_ff[0];
      ctrl.code      = code_ff;
      ctrl.due       = tval_ff;
      ctrl.delta     = delta_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_data_in    = rsp_data_ff;
      rsp_user_in    = rsp_user_ff;
      rsp_last_in    = rsp_last_ff;

      unique case (state_ff)
         des_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               state_in = des_pkg::ST_EXEC;
               phase_in = '0;
               pop_in   = '0;
            end
         end
         des_pkg::ST_EXEC: begin
            status_in = des_pkg::STATUS_OK;
            state_in  = des_pkg::ST_DONE;
            unique case (cmd_ff)
               des_pkg::CMD_PUT: begin
                  if (code_ff == '0) begin
                     status_in = des_pkg::STATUS_INVALID;
                  end else if (code_held) begin
                     ctrl.op  = des_pkg::CELL_RETIME;
                     state_in = des_pkg::ST_SORT;
                  end else if (cell_q[TABLE_DEPTH-1].occ) begin
                     status_in = des_pkg::STATUS_FULL;
                  end else begin
                     ctrl.op  = des_pkg::CELL_APPEND;
                     count_in = count_ff + CNT_W'(1);
                     state_in = des_pkg::ST_SORT;
                  end
               end
               des_pkg::CMD_DELETE: begin
                  if (code_ff == '0) begin
                     status_in = des_pkg::STATUS_INVALID;
                  end else begin
                     // codes are held at most once
                     ctrl.op = des_pkg::CELL_DROP;
                     if (code_held) count_in = count_ff - CNT_W'(1);
                     state_in = des_pkg::ST_SORT;
                  end
               end
               des_pkg::CMD_POLL: begin
                  state_in = des_pkg::ST_POLL;
               end
               des_pkg::CMD_CLEAR: begin
                  ctrl.op  = des_pkg::CELL_CLEAR;
                  count_in = '0;
               end
               des_pkg::CMD_CORRECT: begin
                  ctrl.op  = des_pkg::CELL_SHIFT;
                  state_in = des_pkg::ST_SORT;
               end
               default: begin
                  state_in = des_pkg::ST_DONE;
               end
            endcase
         end
         des_pkg::ST_SORT: begin
            ctrl.op  = des_pkg::CELL_SORT;
            phase_in = phase_ff + PH_W'(1);
            if (phase_ff == PH_W'(TABLE_DEPTH - 1)) state_in = des_pkg::ST_DONE;
         end
         des_pkg::ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {3'b000, des_pkg::OCC_W'(count_ff),
                               des_pkg::CODE_W'(0), status_ff};
               rsp_user_in  = 1'b0;
               rsp_last_in  = 1'b1;
               state_in     = des_pkg::ST_IDLE;
            end
         end
         des_pkg::ST_POLL: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (front_due) begin
                  // pop the head and shift the row down by one
                  ctrl.op     = des_pkg::CELL_POP;
                  count_in    = count_ff - CNT_W'(1);
                  pop_in      = pop_ff + des_pkg::POP_W'(1);
                  rsp_data_in = {3'b000, des_pkg::OCC_W'(count_ff - CNT_W'(1)),
                                 cell_q[0].code, des_pkg::STATUS_OK};
                  rsp_user_in = 1'b1;
                  rsp_last_in = (pop_ff == des_pkg::POP_W'(des_pkg::RESULT_LIMIT - 1))
                                || !next_due;
                  if (rsp_last_in) state_in = des_pkg::ST_IDLE;
               end else begin
                  // nothing due
                  rsp_data_in = {3'b000, des_pkg::OCC_W'(count_ff),
                                 des_pkg::CODE_W'(0), des_pkg::STATUS_OK};
                  rsp_user_in = 1'b0;
                  rsp_last_in = 1'b1;
                  state_in    = des_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = des_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= des_pkg::ST_IDLE;
         phase_ff     <= '0;
         count_ff     <= '0;
         pop_ff       <= '0;
         status_ff    <= des_pkg::STATUS_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         pop_ff       <= pop_in;
         status_ff    <= status_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

`default_nettype wire

// ===== src/des_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module des_cell (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire des_pkg::cell_ctrl_type    ctrl,
   input  wire logic [des_pkg::MASK_W-1:0] shift_mask,
   input  wire logic                      cell_odd,
   input  wire logic                      cell_tail,
   input  wire des_pkg::entry_type        left_entry,
   input  wire des_pkg::entry_type        right_entry,
   output des_pkg::entry_type             entry
);

   des_pkg::entry_type entry_ff;
   des_pkg::entry_type entry_in;
   logic               hit;

   assign hit = entry_ff.occ && (entry_ff.code == ctrl.code);

   // Next slot contents
   always_comb begin
      entry_in = entry_ff;
      unique case (ctrl.op)
         des_pkg::CELL_HOLD: begin
            entry_in = entry_ff;
         end
         des_pkg::CELL_APPEND: begin
            if (cell_tail) begin
               entry_in.occ  = 1'b1;
               entry_in.code = ctrl.code;
               entry_in.due  = ctrl.due;
            end
         end
         des_pkg::CELL_RETIME: begin
            if (hit) entry_in.due = ctrl.due;
         end
         des_pkg::CELL_SHIFT: begin
            if (entry_ff.occ && shift_mask[entry_ff.code]) begin
               entry_in.due = entry_ff.due + ctrl.delta;
            end
         end
         des_pkg::CELL_DROP: begin
            if (hit) entry_in.occ = 1'b0;
         end
         des_pkg::CELL_CLEAR: begin
            entry_in.occ = 1'b0;
         end
         des_pkg::CELL_POP: begin
            entry_in = right_entry;
         end
         des_pkg::CELL_SORT: begin
            // odd-even transposition: left of a pair when parity matches
            if (cell_odd == ctrl.odd_phase) begin
               if (des_pkg::entry_swap(entry_ff, right_entry)) entry_in = right_entry;
            end else begin
               if (des_pkg::entry_swap(left_entry, entry_ff)) entry_in = left_entry;
            end
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.occ <= 1'b0;
      end else begin
         entry_ff <= entry_in;
      end
   end

   assign entry = entry_ff;

endmodule

`default_nettype wire
